@@ hw/rtl/prs_pkg.sv @@
// Shared types and constants for the portfolio return and Sharpe ratio engine
package prs_pkg;

    localparam int MAX_DAYS_DEF   = 256;
    localparam int MAX_STOCKS_DEF = 64;

    localparam logic [8:0] NUM_DAYS_RST   = 9'd252;
    localparam logic [6:0] NUM_STOCKS_RST = 7'd64;
    localparam int         ANN_DAYS       = 252;

    localparam logic CFG_NUM_DAYS   = 1'b0;
    localparam logic CFG_NUM_STOCKS = 1'b1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    localparam logic signed [63:0] LN2_Q56  = 64'sh00B1_7217_F7D1_CF7A;
    localparam logic [31:0]        ONE_Q30  = 32'h4000_0000;
    localparam logic [3:0]         HORN_TOP = 4'd13;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DOT,
        ST_DOT_DRAIN,
        ST_EXP_CHK,
        ST_EXP_RED,
        ST_HORN_MUL,
        ST_HORN_DIV,
        ST_HORN_WAIT,
        ST_EXP_OUT,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_VAR,
        ST_VAR_DRAIN,
        ST_SQ_T,
        ST_SQ_T_WAIT,
        ST_SQ_Q,
        ST_SQ_Q_WAIT,
        ST_NUM_MUL,
        ST_SH_DIV,
        ST_SH_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic {
        ITER_DIV,
        ITER_SQRT
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_req_t;

endpackage

@@ hw/rtl/prs_ram.sv @@
// Generic single write port, single registered read port RAM
module prs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/prs_iter.sv @@
// Shared iterative unit: restoring divide and integer square root, one step per cycle
module prs_iter (
    input  logic                clk,
    input  logic                rst_n,
    input  prs_pkg::iter_req_t  req,
    input  logic [63:0]         a,
    input  logic [63:0]         b,
    output logic                done,
    output logic [63:0]         result
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    prs_pkg::iter_op_t  op_reg, op_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [63:0]        x_reg, x_next;
    logic [64:0]        y_reg, y_next;
    logic [63:0]        b_reg, b_next;

    logic [64:0]        rem_sh;
    logic [65:0]        diff;
    logic [63:0]        root_try;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        b_next    = b_reg;
        rem_sh    = {y_reg[63:0], x_reg[63]};
        diff      = {1'b0, rem_sh} - {2'b00, b_reg};
        root_try  = y_reg[63:0] + b_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            x_next    = a;
            y_next    = '0;
            if (req.op == prs_pkg::ITER_DIV)
            begin
                b_next   = b;
                cnt_next = 7'd64;
            end
            else
            begin
                b_next   = 64'h4000_0000_0000_0000;
                cnt_next = 7'd32;
            end
        end
        else if (busy_reg)
        begin
            case (op_reg)
                prs_pkg::ITER_DIV:
                begin
                    if (!diff[65])
                    begin
                        y_next = diff[64:0];
                        x_next = {x_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        y_next = rem_sh;
                        x_next = {x_reg[62:0], 1'b0};
                    end
                end
                prs_pkg::ITER_SQRT:
                begin
                    if (x_reg >= root_try)
                    begin
                        x_next = x_reg - root_try;
                        y_next = {1'b0, (y_reg[63:0] >> 1) + b_reg};
                    end
                    else
                    begin
                        y_next = {1'b0, y_reg[63:0] >> 1};
                    end
                    b_next = b_reg >> 2;
                end
                default:
                begin
                    y_next = y_reg;
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= prs_pkg::ITER_DIV;
            cnt_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            b_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            b_reg    <= b_next;
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == prs_pkg::ITER_DIV) ? x_reg : y_reg[63:0];

endmodule

@@ hw/rtl/portfolio_return_sharpe.sv @@
// Top level: return matrix load, weighted daily returns, expm1 and Sharpe ratio
// Loads and all but the last weight of a portfolio are taken while idle, next beat at once.
// Last weight (T days, U stocks): the dot product runs one multiply per cycle on the
// shared multiplier, then expm1, mean, variance (on the multiplier), two square roots
// and the Sharpe quotient; all but the variance use the shared divide/sqrt unit.
// Reset (async, active low) clears positions, counter, registers to 252 days, 64 stocks.
module portfolio_return_sharpe #(
    parameter int MAX_DAYS   = prs_pkg::MAX_DAYS_DEF,
    parameter int MAX_STOCKS = prs_pkg::MAX_STOCKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               operation,
    input  logic signed [31:0] value,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [15:0]        portfolio_index,
    output logic signed [31:0] cumulative_return,
    output logic signed [31:0] sharpe_ratio
);

    localparam int TW    = $clog2(MAX_DAYS + 1);
    localparam int UW    = $clog2(MAX_STOCKS + 1);
    localparam int DAW   = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
    localparam int WAW   = (MAX_STOCKS > 1) ? $clog2(MAX_STOCKS) : 1;
    localparam int DEPTH = MAX_DAYS * MAX_STOCKS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = TW + UW;
    localparam int ACC_W = 36 + WAW;
    localparam int SUM_W = 33 + DAW;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < -66'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    prs_pkg::state_t state_reg, state_next;

    logic [8:0]  num_days_reg, num_days_next;
    logic [6:0]  num_stocks_reg, num_stocks_next;
    logic [LW-1:0] lpos_reg, lpos_next;
    logic [UW-1:0] wpos_reg, wpos_next;
    logic [15:0] pidx_reg, pidx_next;

    logic [UW-1:0]  s_cnt_reg, s_cnt_next;
    logic [TW-1:0]  d_cnt_reg, d_cnt_next;
    logic [AW-1:0]  addr_reg, addr_next;

    logic           dv1_reg, dv1_next, dv2_reg, dv2_next, dv3_reg, dv3_next;
    logic           dlast1_reg, dlast1_next, dlast2_reg, dlast2_next;
    logic           dfirst1_reg, dfirst1_next, dfirst2_reg, dfirst2_next;
    logic [DAW-1:0] dday1_reg, dday1_next, dday2_reg, dday2_next, dday3_reg, dday3_next;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    logic        vv1_reg, vv1_next, vv2_reg, vv2_next, vv3_reg, vv3_next;
    logic [31:0] dm_reg, dm_next;
    logic [63:0] qsum_reg, qsum_next;

    logic signed [63:0] xr_reg, xr_next;
    logic signed [7:0]  k_reg, k_next;
    logic [29:0]        rq_reg, rq_next;
    logic [31:0]        e_reg, e_next;
    logic [3:0]         n_reg, n_next;

    logic signed [32:0] mean_reg, mean_next;
    logic [31:0]        sr_reg, sr_next;
    logic [31:0]        sq_reg, sq_next;
    logic signed [31:0] cum_reg, cum_next;
    logic signed [31:0] sh_reg, sh_next;

    logic               res_valid_reg, res_valid_next;
    logic [15:0]        res_idx_reg, res_idx_next;
    logic signed [31:0] res_cum_reg, res_cum_next;
    logic signed [31:0] res_sh_reg, res_sh_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_reg;

    logic [TW-1:0]   t_eff;
    logic [UW-1:0]   u_eff;
    logic [LW-1:0]   limit;
    logic [LW-1:0]   lp_cur, lp_inc;
    logic [UW-1:0]   wp_cur, wp_inc;
    logic            item_acc;

    logic            st_wr_en, wt_wr_en, dy_wr_en;
    logic [AW-1:0]   st_wr_addr;
    logic [WAW-1:0]  wt_wr_addr;
    logic [31:0]     st_rd, wt_rd, dy_rd;
    logic [DAW-1:0]  dy_rd_addr;
    logic signed [31:0] day_val;

    prs_pkg::iter_req_t iter_req;
    logic [63:0]        iter_a, iter_b, iter_res;
    logic               iter_done;

    logic signed [63:0] prod64, prod_rnd;
    logic signed [34:0] term;
    logic signed [63:0] sum64;
    logic [63:0]        mag;
    logic signed [33:0] dev;
    logic [33:0]        dev_abs;
    logic [32:0]        mean_abs;
    logic [TW+7:0]      ann_t;
    logic [63:0]        den;
    logic signed [7:0]  s_val;
    logic [5:0]         sh_amt;
    logic [63:0]        ev;
    logic signed [65:0] vd;
    logic [31:0]        qm;

    assign t_eff = (32'(num_days_reg) > 32'(MAX_DAYS)) ? TW'(MAX_DAYS) : TW'(num_days_reg);
    assign u_eff = (32'(num_stocks_reg) > 32'(MAX_STOCKS)) ? UW'(MAX_STOCKS)
                                                           : UW'(num_stocks_reg);
    assign limit  = LW'(t_eff) * LW'(u_eff);
    assign lp_cur = (lpos_reg >= limit) ? '0 : lpos_reg;
    assign lp_inc = lp_cur + 1'b1;
    assign wp_cur = (wpos_reg >= u_eff) ? '0 : wpos_reg;
    assign wp_inc = wp_cur + 1'b1;

    assign item_stall = (state_reg != prs_pkg::ST_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    assign st_wr_en   = item_acc && (operation == prs_pkg::OP_LOAD) && (limit != '0);
    assign st_wr_addr = lp_cur[AW-1:0];
    assign wt_wr_en   = item_acc && (operation == prs_pkg::OP_WEIGHT) && (u_eff != '0);
    assign wt_wr_addr = wp_cur[WAW-1:0];
    assign day_val    = sat32(66'(acc_reg));
    assign dy_wr_en   = dv3_reg;
    assign dy_rd_addr = d_cnt_reg[DAW-1:0];

    prs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (value),
        .rd_addr (addr_reg),
        .rd_data (st_rd)
    );

    prs_ram #(.WIDTH(32), .DEPTH(MAX_STOCKS)) u_weights (
        .clk     (clk),
        .wr_en   (wt_wr_en),
        .wr_addr (wt_wr_addr),
        .wr_data (value),
        .rd_addr (s_cnt_reg[WAW-1:0]),
        .rd_data (wt_rd)
    );

    prs_ram #(.WIDTH(32), .DEPTH(MAX_DAYS)) u_daily (
        .clk     (clk),
        .wr_en   (dy_wr_en),
        .wr_addr (dday3_reg),
        .wr_data (day_val),
        .rd_addr (dy_rd_addr),
        .rd_data (dy_rd)
    );

    prs_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (iter_req),
        .a      (iter_a),
        .b      (iter_b),
        .done   (iter_done),
        .result (iter_res)
    );

    always_comb
    begin
        case (state_reg)
            prs_pkg::ST_DOT, prs_pkg::ST_DOT_DRAIN:
            begin
                mul_a = $signed({st_rd[31], st_rd});
                mul_b = $signed({wt_rd[31], wt_rd});
            end
            prs_pkg::ST_VAR, prs_pkg::ST_VAR_DRAIN:
            begin
                mul_a = $signed({1'b0, dm_reg});
                mul_b = $signed({1'b0, dm_reg});
            end
            prs_pkg::ST_HORN_MUL:
            begin
                mul_a = $signed({3'b000, rq_reg});
                mul_b = $signed({1'b0, e_reg});
            end
            prs_pkg::ST_NUM_MUL:
            begin
                mul_a = $signed({1'b0, mean_abs[31:0]});
                mul_b = $signed({1'b0, sr_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        state_next      = state_reg;
        num_days_next   = num_days_reg;
        num_stocks_next = num_stocks_reg;
        lpos_next       = lpos_reg;
        wpos_next       = wpos_reg;
        pidx_next       = pidx_reg;
        s_cnt_next      = s_cnt_reg;
        d_cnt_next      = d_cnt_reg;
        addr_next       = addr_reg;
        acc_next        = acc_reg;
        sum_next        = sum_reg;
        dm_next         = dm_reg;
        qsum_next       = qsum_reg;
        xr_next         = xr_reg;
        k_next          = k_reg;
        rq_next         = rq_reg;
        e_next          = e_reg;
        n_next          = n_reg;
        mean_next       = mean_reg;
        sr_next         = sr_reg;
        sq_next         = sq_reg;
        cum_next        = cum_reg;
        sh_next         = sh_reg;
        res_idx_next    = res_idx_reg;
        res_cum_next    = res_cum_reg;
        res_sh_next     = res_sh_reg;
        res_valid_next  = res_valid_reg && result_stall;
        iter_req.start  = 1'b0;
        iter_req.op     = prs_pkg::ITER_DIV;
        iter_a          = '0;
        iter_b          = '0;

        sum64    = 64'(sum_reg);
        mag      = (sum64 < 0) ? 64'(-sum64) : 64'(sum64);
        mean_abs = (mean_reg < 0) ? 33'(-mean_reg) : 33'(mean_reg);
        ann_t    = (TW + 8)'(prs_pkg::ANN_DAYS) * (TW + 8)'(t_eff - 1'b1);
        den      = {24'd0, sq_reg, 8'd0};
        prod64   = mul_reg[63:0];
        prod_rnd = prod64 + 64'sd268435456;
        term     = prod_rnd[63:29];
        dev      = $signed({{2{dy_rd[31]}}, dy_rd}) - $signed({mean_reg[32], mean_reg});
        dev_abs  = (dev < 0) ? 34'(-dev) : 34'(dev);
        s_val    = 8'sd14 - k_reg;
        sh_amt   = s_val[5:0];
        if (s_val > 0)
        begin
            ev = (64'(e_reg) + (64'd1 << (sh_amt - 6'd1))) >> sh_amt;
        end
        else if (s_val == 0)
        begin
            ev = 64'(e_reg);
        end
        else
        begin
            ev = 64'(e_reg) << 1;
        end
        vd = $signed({2'b00, ev}) - 66'sd65536;
        qm = iter_res[31:0];

        dv1_next     = 1'b0;
        dlast1_next  = (s_cnt_reg == u_eff - 1'b1);
        dfirst1_next = (s_cnt_reg == '0);
        dday1_next   = d_cnt_reg[DAW-1:0];
        dv2_next     = dv1_reg;
        dlast2_next  = dlast1_reg;
        dfirst2_next = dfirst1_reg;
        dday2_next   = dday1_reg;
        dv3_next     = dv2_reg && dlast2_reg;
        dday3_next   = dday2_reg;
        vv1_next     = 1'b0;
        vv2_next     = vv1_reg;
        vv3_next     = vv2_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                prs_pkg::CFG_NUM_DAYS:   num_days_next   = cfg_data;
                prs_pkg::CFG_NUM_STOCKS: num_stocks_next = cfg_data[6:0];
                default:                 num_days_next   = num_days_reg;
            endcase
        end

        if (dv2_reg)
        begin
            acc_next = (dfirst2_reg ? '0 : acc_reg) + ACC_W'(term);
        end
        if (dv3_reg)
        begin
            sum_next = sum_reg + SUM_W'(day_val);
        end
        if (vv1_reg)
        begin
            dm_next = dev_abs[31:0];
        end
        if (vv3_reg)
        begin
            qsum_next = qsum_reg + ((mul_reg[63:0] + 64'd32768) >> 16);
        end

        case (state_reg)
            prs_pkg::ST_IDLE:
            begin
                if (item_acc && (operation == prs_pkg::OP_LOAD))
                begin
                    if (limit != '0)
                    begin
                        lpos_next = (lp_inc >= limit) ? '0 : lp_inc;
                    end
                end
                else if (item_acc && (u_eff != '0))
                begin
                    if (wp_inc < u_eff)
                    begin
                        wpos_next = wp_inc;
                    end
                    else
                    begin
                        wpos_next  = '0;
                        s_cnt_next = '0;
                        d_cnt_next = '0;
                        addr_next  = '0;
                        sum_next   = '0;
                        state_next = (t_eff == '0) ? prs_pkg::ST_EXP_CHK : prs_pkg::ST_DOT;
                    end
                end
            end
            prs_pkg::ST_DOT:
            begin
                dv1_next  = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (s_cnt_reg == u_eff - 1'b1)
                begin
                    s_cnt_next = '0;
                    d_cnt_next = d_cnt_reg + 1'b1;
                    if (d_cnt_reg == t_eff - 1'b1)
                    begin
                        state_next = prs_pkg::ST_DOT_DRAIN;
                    end
                end
                else
                begin
                    s_cnt_next = s_cnt_reg + 1'b1;
                end
            end
            prs_pkg::ST_DOT_DRAIN:
            begin
                if (!dv1_reg && !dv2_reg && !dv3_reg)
                begin
                    state_next = prs_pkg::ST_EXP_CHK;
                end
            end
            prs_pkg::ST_EXP_CHK:
            begin
                if (sum64 >= (64'sd11 <<< 29))
                begin
                    cum_next   = 32'sh7FFF_FFFF;
                    state_next = prs_pkg::ST_MEAN;
                end
                else if (sum64 < -(64'sd32 <<< 29))
                begin
                    cum_next   = -32'sd65536;
                    state_next = prs_pkg::ST_MEAN;
                end
                else
                begin
                    xr_next    = sum64 <<< 27;
                    k_next     = '0;
                    state_next = prs_pkg::ST_EXP_RED;
                end
            end
            prs_pkg::ST_EXP_RED:
            begin
                if (xr_reg < 0)
                begin
                    xr_next = xr_reg + prs_pkg::LN2_Q56;
                    k_next  = k_reg - 8'sd1;
                end
                else if (xr_reg >= prs_pkg::LN2_Q56)
                begin
                    xr_next = xr_reg - prs_pkg::LN2_Q56;
                    k_next  = k_reg + 8'sd1;
                end
                else
                begin
                    rq_next    = xr_reg[55:26];
                    e_next     = prs_pkg::ONE_Q30;
                    n_next     = prs_pkg::HORN_TOP;
                    state_next = prs_pkg::ST_HORN_MUL;
                end
            end
            prs_pkg::ST_HORN_MUL:
            begin
                state_next = prs_pkg::ST_HORN_DIV;
            end
            prs_pkg::ST_HORN_DIV:
            begin
                iter_req.start = 1'b1;
                iter_req.op    = prs_pkg::ITER_DIV;
                iter_a         = {30'd0, mul_reg[63:30]};
                iter_b         = {60'd0, n_reg};
                state_next     = prs_pkg::ST_HORN_WAIT;
            end
            prs_pkg::ST_HORN_WAIT:
            begin
                if (iter_done)
                begin
                    e_next = prs_pkg::ONE_Q30 + iter_res[31:0];
                    n_next = n_reg - 4'd1;
                    state_next = (n_reg == 4'd1) ? prs_pkg::ST_EXP_OUT
                                                 : prs_pkg::ST_HORN_MUL;
                end
            end
            prs_pkg::ST_EXP_OUT:
            begin
                cum_next   = sat32(vd);
                state_next = prs_pkg::ST_MEAN;
            end
            prs_pkg::ST_MEAN:
            begin
                qsum_next = '0;
                if (t_eff < TW'(2))
                begin
                    sh_next    = '0;
                    state_next = prs_pkg::ST_OUT;
                end
                else
                begin
                    iter_req.start = 1'b1;
                    iter_req.op    = prs_pkg::ITER_DIV;
                    iter_a         = mag + 64'(t_eff >> 1);
                    iter_b         = 64'(t_eff);
                    state_next     = prs_pkg::ST_MEAN_WAIT;
                end
            end
            prs_pkg::ST_MEAN_WAIT:
            begin
                if (iter_done)
                begin
                    mean_next  = sum_reg[SUM_W-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
                    d_cnt_next = '0;
                    state_next = prs_pkg::ST_VAR;
                end
            end
            prs_pkg::ST_VAR:
            begin
                vv1_next   = 1'b1;
                d_cnt_next = d_cnt_reg + 1'b1;
                if (d_cnt_reg == t_eff - 1'b1)
                begin
                    state_next = prs_pkg::ST_VAR_DRAIN;
                end
            end
            prs_pkg::ST_VAR_DRAIN:
            begin
                if (!vv1_reg && !vv2_reg && !vv3_reg)
                begin
                    if (qsum_reg == '0)
                    begin
                        sh_next    = '0;
                        state_next = prs_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = prs_pkg::ST_SQ_T;
                    end
                end
            end
            prs_pkg::ST_SQ_T:
            begin
                iter_req.start = 1'b1;
                iter_req.op    = prs_pkg::ITER_SQRT;
                iter_a         = 64'(ann_t) << 32;
                state_next     = prs_pkg::ST_SQ_T_WAIT;
            end
            prs_pkg::ST_SQ_T_WAIT:
            begin
                if (iter_done)
                begin
                    sr_next    = iter_res[31:0];
                    state_next = prs_pkg::ST_SQ_Q;
                end
            end
            prs_pkg::ST_SQ_Q:
            begin
                iter_req.start = 1'b1;
                iter_req.op    = prs_pkg::ITER_SQRT;
                iter_a         = qsum_reg;
                state_next     = prs_pkg::ST_SQ_Q_WAIT;
            end
            prs_pkg::ST_SQ_Q_WAIT:
            begin
                if (iter_done)
                begin
                    sq_next    = iter_res[31:0];
                    state_next = prs_pkg::ST_NUM_MUL;
                end
            end
            prs_pkg::ST_NUM_MUL:
            begin
                state_next = prs_pkg::ST_SH_DIV;
            end
            prs_pkg::ST_SH_DIV:
            begin
                iter_req.start = 1'b1;
                iter_req.op    = prs_pkg::ITER_DIV;
                iter_a         = mul_reg[63:0] + (den >> 1);
                iter_b         = den;
                state_next     = prs_pkg::ST_SH_WAIT;
            end
            prs_pkg::ST_SH_WAIT:
            begin
                if (iter_done)
                begin
                    if (mean_reg < 0)
                    begin
                        sh_next = (iter_res >= 64'h8000_0000) ? 32'sh8000_0000
                                                             : -$signed(iter_res[31:0]);
                    end
                    else
                    begin
                        sh_next = (iter_res >= 64'h8000_0000) ? 32'sh7FFF_FFFF
                                                             : $signed(iter_res[31:0]);
                    end
                    state_next = prs_pkg::ST_OUT;
                end
            end
            prs_pkg::ST_OUT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next = 1'b1;
                    res_idx_next   = pidx_reg;
                    res_cum_next   = cum_reg;
                    res_sh_next    = sh_reg;
                    pidx_next      = pidx_reg + 16'd1;
                    state_next     = prs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_days_reg   <= prs_pkg::NUM_DAYS_RST;
            num_stocks_reg <= prs_pkg::NUM_STOCKS_RST;
            lpos_reg       <= '0;
            wpos_reg       <= '0;
            pidx_reg       <= '0;
            s_cnt_reg      <= '0;
            d_cnt_reg      <= '0;
            addr_reg       <= '0;
            dv1_reg        <= 1'b0;
            dv2_reg        <= 1'b0;
            dv3_reg        <= 1'b0;
            vv1_reg        <= 1'b0;
            vv2_reg        <= 1'b0;
            vv3_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            num_days_reg   <= num_days_next;
            num_stocks_reg <= num_stocks_next;
            lpos_reg       <= lpos_next;
            wpos_reg       <= wpos_next;
            pidx_reg       <= pidx_next;
            s_cnt_reg      <= s_cnt_next;
            d_cnt_reg      <= d_cnt_next;
            addr_reg       <= addr_next;
            dv1_reg        <= dv1_next;
            dv2_reg        <= dv2_next;
            dv3_reg        <= dv3_next;
            vv1_reg        <= vv1_next;
            vv2_reg        <= vv2_next;
            vv3_reg        <= vv3_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dlast1_reg  <= dlast1_next;
        dlast2_reg  <= dlast2_next;
        dfirst1_reg <= dfirst1_next;
        dfirst2_reg <= dfirst2_next;
        dday1_reg   <= dday1_next;
        dday2_reg   <= dday2_next;
        dday3_reg   <= dday3_next;
        acc_reg     <= acc_next;
        sum_reg     <= sum_next;
        dm_reg      <= dm_next;
        qsum_reg    <= qsum_next;
        xr_reg      <= xr_next;
        k_reg       <= k_next;
        rq_reg      <= rq_next;
        e_reg       <= e_next;
        n_reg       <= n_next;
        mean_reg    <= mean_next;
        sr_reg      <= sr_next;
        sq_reg      <= sq_next;
        cum_reg     <= cum_next;
        sh_reg      <= sh_next;
        res_idx_reg <= res_idx_next;
        res_cum_reg <= res_cum_next;
        res_sh_reg  <= res_sh_next;
    end

    assign result_valid      = res_valid_reg;
    assign portfolio_index   = res_idx_reg;
    assign cumulative_return = res_cum_reg;
    assign sharpe_ratio      = res_sh_reg;

endmodule

@@ hw/rtl/prs_checker.sv @@
// Port-level checks for the portfolio return and Sharpe ratio engine
module prs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic               operation,
    input logic               result_valid,
    input logic               result_stall,
    input logic [15:0]        portfolio_index,
    input logic signed [31:0] cumulative_return,
    input logic signed [31:0] sharpe_ratio
);

    logic [15:0] expect_reg, expect_next;
    logic        res_beat;

    assign res_beat    = result_valid && !result_stall;
    assign expect_next = res_beat ? expect_reg + 16'd1 : expect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg <= '0;
        end
        else
        begin
            expect_reg <= expect_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(portfolio_index)
            && $stable(cumulative_return) && $stable(sharpe_ratio))
        else $error("result beat dropped or changed while stalled");

    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        res_beat |-> portfolio_index == expect_reg)
        else $error("portfolio index out of sequence");

    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && operation == prs_pkg::OP_LOAD |=> !item_stall)
        else $error("load beat stalled the input");

    a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without a computation");

endmodule

bind portfolio_return_sharpe prs_checker u_prs_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for the portfolio return and Sharpe ratio engine
`timescale 1ns / 100ps

module tb_top;

    typedef bit [63:0] u64_t;

    typedef struct {
        logic [15:0]        idx;
        logic signed [31:0] cum;
        logic signed [31:0] shp;
    } folio_t;

    localparam int STALL_LIMIT = 200000;
    localparam int SETTLE      = 20;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [8:0]         cfg_data;
    logic               item_valid;
    logic               item_stall;
    logic               operation;
    logic signed [31:0] value;
    logic               result_valid;
    logic               result_stall;
    logic [15:0]        portfolio_index;
    logic signed [31:0] cumulative_return;
    logic signed [31:0] sharpe_ratio;

    logic signed [31:0] ret_mem [16384];
    logic signed [31:0] wts [64];
    longint             day_ret [256];
    int                 ld_pos;
    int                 wt_pos;
    logic [15:0]        pf_count;
    logic [8:0]         days_cfg;
    logic [6:0]         stocks_cfg;

    folio_t             folio_q [$];
    int                 mismatches;
    int                 beats_sent;
    int                 quiet_cycles;
    bit                 calm;

    portfolio_return_sharpe u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .operation         (operation),
        .value             (value),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .portfolio_index   (portfolio_index),
        .cumulative_return (cumulative_return),
        .sharpe_ratio      (sharpe_ratio)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic signed [31:0] sat32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (x < -64'sd2147483648)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic u64_t int_sqrt(u64_t v);
        u64_t res;
        u64_t b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] expm1_q16(longint x);
        u64_t   ln2;
        u64_t   one;
        longint x56;
        longint k;
        u64_t   q;
        u64_t   r;
        u64_t   e;
        u64_t   v;
        int     s;
        ln2 = u64_t'(prs_pkg::LN2_Q56);
        one = u64_t'(prs_pkg::ONE_Q30);
        if (x >= (longint'(11) <<< 29))
            return 32'sh7fff_ffff;
        if (x < -(longint'(32) <<< 29))
            return -32'sd65536;
        x56 = x * (longint'(1) <<< 27);
        if (x56 >= 0)
            k = longint'(u64_t'(x56) / ln2);
        else
        begin
            q = (u64_t'(-x56) + ln2 - 1) / ln2;
            k = -longint'(q);
        end
        r = u64_t'(x56 - k * longint'(ln2));
        r = r >> 26;
        e = one;
        for (int n = 13; n >= 1; n--)
            e = one + ((r * e) >> 30) / u64_t'(n);
        s = 14 - int'(k);
        if (s > 0)
            v = (e + (u64_t'(1) << (s - 1))) >> s;
        else
            v = e << (-s);
        return sat32(longint'(v) - 65536);
    endfunction

    task automatic predict_beat(logic op, logic signed [31:0] val);
        int     t;
        int     u;
        int     lim;
        longint sum;
        longint acc;
        longint prod;
        longint mean;
        longint dev;
        u64_t   mag;
        u64_t   qsum;
        u64_t   num;
        u64_t   den;
        u64_t   q;
        folio_t f;
        t = (days_cfg < 256) ? days_cfg : 256;
        u = (stocks_cfg < 64) ? stocks_cfg : 64;
        if (op == prs_pkg::OP_LOAD)
        begin
            lim = t * u;
            if (lim == 0)
                return;
            if (ld_pos >= lim)
                ld_pos = 0;
            ret_mem[ld_pos] = val;
            ld_pos++;
            if (ld_pos >= lim)
                ld_pos = 0;
            return;
        end
        if (u == 0)
            return;
        if (wt_pos >= u)
            wt_pos = 0;
        wts[wt_pos] = val;
        wt_pos++;
        if (wt_pos < u)
            return;
        wt_pos = 0;
        sum = 0;
        for (int d = 0; d < t; d++)
        begin
            acc = 0;
            for (int s = 0; s < u; s++)
            begin
                prod = longint'(wts[s]) * longint'(ret_mem[d * u + s]);
                acc += (prod + (longint'(1) <<< 28)) >>> 29;
            end
            day_ret[d] = longint'(sat32(acc));
            sum += day_ret[d];
        end
        f.idx = pf_count;
        f.cum = expm1_q16(sum);
        f.shp = 0;
        if (t >= 2)
        begin
            mag = (sum < 0) ? u64_t'(-sum) : u64_t'(sum);
            q = (mag + u64_t'(t / 2)) / u64_t'(t);
            mean = (sum < 0) ? -longint'(q) : longint'(q);
            qsum = 0;
            for (int d = 0; d < t; d++)
            begin
                dev = day_ret[d] - mean;
                mag = (dev < 0) ? u64_t'(-dev) : u64_t'(dev);
                qsum += (mag * mag + (u64_t'(1) << 15)) >> 16;
            end
            if (qsum != 0)
            begin
                mag = (mean < 0) ? u64_t'(-mean) : u64_t'(mean);
                num = mag * int_sqrt(u64_t'(prs_pkg::ANN_DAYS * (t - 1)) << 32);
                den = int_sqrt(qsum) << 8;
                q = (num + den / 2) / den;
                if (q > 64'h8000_0000)
                    q = 64'h8000_0000;
                f.shp = sat32((mean < 0) ? -longint'(q) : longint'(q));
            end
        end
        folio_q.push_back(f);
        pf_count++;
    endtask

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        folio_t f;
        if (rst_n && result_valid && !result_stall)
        begin
            if (folio_q.size() == 0)
                flag_mismatch($sformatf("unexpected result index %0d", portfolio_index));
            else
            begin
                f = folio_q.pop_front();
                if (portfolio_index !== f.idx)
                    flag_mismatch($sformatf("portfolio_index exp %0d got %0d",
                                            f.idx, portfolio_index));
                if (cumulative_return !== f.cum)
                    flag_mismatch($sformatf("cumulative_return #%0d exp %h got %h",
                                            f.idx, f.cum, cumulative_return));
                if (sharpe_ratio !== f.shp)
                    flag_mismatch($sformatf("sharpe_ratio #%0d exp %h got %h",
                                            f.idx, f.shp, sharpe_ratio));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[portfolio_return_sharpe] ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        result_stall <= !calm && ($urandom_range(99) < 35);

    function automatic logic signed [31:0] rand_q(int span);
        if ($urandom_range(99) < 20)
            return $urandom;
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_beat(logic op, logic signed [31:0] val);
        if (!calm)
        begin
            while ($urandom_range(99) < 35)
            begin
                item_valid <= 1'b0;
                @(negedge clk);
            end
        end
        item_valid <= 1'b1;
        operation  <= op;
        value      <= val;
        do
            @(posedge clk);
        while (item_stall);
        predict_beat(op, val);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic drain_wait();
        item_valid <= 1'b0;
        while (folio_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == prs_pkg::CFG_NUM_DAYS)
            days_cfg = data;
        else
            stocks_cfg = data[6:0];
        @(negedge clk);
    endtask

    task automatic set_shape(logic [8:0] days, logic [8:0] stocks);
        drain_wait();
        write_reg(prs_pkg::CFG_NUM_DAYS, days);
        write_reg(prs_pkg::CFG_NUM_STOCKS, stocks);
        cfg_valid <= 1'b0;
    endtask

    function automatic int matrix_size();
        return ((days_cfg < 256) ? days_cfg : 256) * ((stocks_cfg < 64) ? stocks_cfg : 64);
    endfunction

    task automatic fill_matrix(int span);
        int n;
        n = matrix_size();
        for (int i = 0; i < n; i++)
            send_beat(prs_pkg::OP_LOAD, rand_q(span));
    endtask

    task automatic send_portfolio(int span);
        int u;
        u = (stocks_cfg < 64) ? stocks_cfg : 64;
        for (int i = 0; i < u; i++)
            send_beat(prs_pkg::OP_WEIGHT, rand_q(span));
    endtask

    task automatic test_full_size();
        calm = 1'b1;
        set_shape(9'd300, 9'd2);
        fill_matrix(1 << 21);
        send_portfolio(1 << 24);
        set_shape(9'd3, 9'd127);
        calm = 1'b0;
        fill_matrix(1 << 21);
        send_portfolio(1 << 24);
        for (int i = 0; i < 64; i++)
            send_beat(prs_pkg::OP_WEIGHT, (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000);
    endtask

    task automatic test_corners();
        set_shape(9'd1, 9'd2);
        fill_matrix(1 << 22);
        send_portfolio(1 << 28);
        set_shape(9'd0, 9'd3);
        send_beat(prs_pkg::OP_LOAD, 32'sh1234_5678);
        send_portfolio(1 << 28);
        set_shape(9'd4, 9'd0);
        send_beat(prs_pkg::OP_LOAD, 32'sh0000_0001);
        send_beat(prs_pkg::OP_WEIGHT, 32'sh2000_0000);
        send_beat(prs_pkg::OP_WEIGHT, 32'sh8000_0000);
        set_shape(9'd3, 9'd1);
        for (int i = 0; i < 3; i++)
            send_beat(prs_pkg::OP_LOAD, 32'sh0010_0000);
        send_beat(prs_pkg::OP_WEIGHT, 32'sh2000_0000);
        set_shape(9'd16, 9'd1);
        for (int i = 0; i < 16; i++)
            send_beat(prs_pkg::OP_LOAD, 32'sh7fff_ffff);
        send_beat(prs_pkg::OP_WEIGHT, 32'sh7fff_ffff);
        send_beat(prs_pkg::OP_WEIGHT, 32'sh8000_0000);
        set_shape(9'd4, 9'd1);
        for (int i = 0; i < 4; i++)
            send_beat(prs_pkg::OP_LOAD, (i == 3) ? 32'sh2000_0001 : 32'sh2000_0000);
        send_beat(prs_pkg::OP_WEIGHT, 32'sh2000_0000);
        send_beat(prs_pkg::OP_WEIGHT, 32'sh8000_0000);
    endtask

    task automatic test_shape_change();
        set_shape(9'd2, 9'd4);
        fill_matrix(1 << 22);
        for (int i = 0; i < 3; i++)
            send_beat(prs_pkg::OP_WEIGHT, rand_q(1 << 27));
        send_beat(prs_pkg::OP_LOAD, rand_q(1 << 22));
        set_shape(9'd2, 9'b110_000_010);
        fill_matrix(1 << 22);
        send_portfolio(1 << 27);
    endtask

    task automatic test_random();
        int days;
        int stocks;
        int u;
        int pick;
        while (beats_sent < 1800)
        begin
            pick = $urandom_range(99);
            days = (pick < 10) ? $urandom_range(0, 1) : $urandom_range(2, 12);
            stocks = (pick > 94) ? $urandom_range(65, 127) : $urandom_range(0, 6);
            set_shape(9'(days), {2'($urandom), 7'(stocks)});
            calm = ($urandom_range(9) == 0);
            fill_matrix(1 << $urandom_range(16, 24));
            u = (stocks_cfg < 64) ? stocks_cfg : 64;
            for (int k = 0; k < 10; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    send_portfolio(1 << $urandom_range(24, 29));
                else if (pick < 90)
                    send_beat(prs_pkg::OP_LOAD, rand_q(1 << 22));
                else
                    for (int i = 0; i < $urandom_range(0, u); i++)
                        send_beat(prs_pkg::OP_WEIGHT, rand_q(1 << 27));
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = prs_pkg::CFG_NUM_DAYS;
        cfg_data     = '0;
        item_valid   = 1'b0;
        operation    = prs_pkg::OP_LOAD;
        value        = '0;
        calm         = 1'b0;
        beats_sent   = 0;
        ld_pos       = 0;
        wt_pos       = 0;
        pf_count     = '0;
        days_cfg     = prs_pkg::NUM_DAYS_RST;
        stocks_cfg   = prs_pkg::NUM_STOCKS_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_full_size();
        test_corners();
        test_shape_change();
        test_random();
        drain_wait();
        repeat (50) @(negedge clk);
        if (mismatches == 0)
            $display("[portfolio_return_sharpe] OK");
        else
            $display("[portfolio_return_sharpe] ERROR");
        $finish;
    end

endmodule
